FILE: rtl/ffa_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the first-fit free list allocator
package ffa_pkg;
  localparam int unsigned ListEntries = 4096;
  localparam int unsigned IdxW = $clog2(ListEntries);
  localparam int unsigned CntW = $clog2(ListEntries + 1);
  localparam int unsigned EntW = 64;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] len;
  } entry_t;
endpackage

FILE: rtl/ffa_ram.sv
`timescale 1ns / 1ps
// generic synchronous ram with one write port and one registered read port
module ffa_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: rtl/ffa_ctrl.sv
`timescale 1ns / 1ps
// sequencer that scans, shifts and patches the free list in memory
module ffa_ctrl import ffa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [31:0]       req_addr_i,
  input  logic [31:0]       req_size_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       alloc_addr_o,
  output logic              status_o,
  output logic [31:0]       free_total_o,
  output logic [12:0]       entry_count_o,
  output logic [12:0]       peak_entries_o,
  output logic [31:0]       lost_count_o,
  output logic [31:0]       lost_bytes_o,
  output logic              we_o,
  output logic [IdxW-1:0]   waddr_o,
  output entry_t            wdata_o,
  output logic [IdxW-1:0]   raddr_o,
  input  entry_t            rdata_i
);
  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_W, S_RMV, S_RMV_W, S_INS, S_INS_W, S_DONE
  } state_e;

  state_e state_q;
  logic              act_q;
  logic [31:0]       addr_q, size_q;
  logic [CntW-1:0]   used_q, max_q;
  logic [CntW-1:0]   pos_q;
  logic [31:0]       lost_n_q, lost_b_q, free_q;
  entry_t            prev_q;
  entry_t            new_q;
  logic              rd_q;
  logic [31:0]       res_addr_q;
  logic              res_fail_q;

  // read address driven from pos, or from the shift source in the shift states
  logic [CntW-1:0] rd_ptr;
  logic            busy;
  logic [31:0]     req_end;

  assign busy = (state_q != S_IDLE);
  assign in_stall_o = busy || out_valid_o;
  assign req_end = addr_q + size_q;

  always_comb begin
    rd_ptr = pos_q;
    if (state_q == S_INS) begin
      rd_ptr = pos_q - CntW'(1);
    end else if (state_q == S_RMV) begin
      rd_ptr = pos_q + CntW'(1);
    end
  end
  assign raddr_o = rd_ptr[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q <= '0;
      max_q <= '0;
      lost_n_q <= '0;
      lost_b_q <= '0;
      free_q <= '0;
      out_valid_o <= 1'b0;
      we_o <= 1'b0;
      pos_q <= '0;
      rd_q <= 1'b0;
    end else begin
      we_o <= 1'b0;
      if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && !out_valid_o) begin
            act_q <= action_i;
            addr_q <= req_addr_i;
            size_q <= req_size_i;
            pos_q <= '0;
            rd_q <= 1'b0;
            res_addr_q <= '0;
            res_fail_q <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // read of entry pos issued this cycle
          if (pos_q >= used_q) begin
            if (act_q == ACT_ALLOC) begin
              res_fail_q <= 1'b1;
              state_q <= S_DONE;
            end else if (pos_q != '0 && prev_q.base + prev_q.len == addr_q) begin
              we_o <= 1'b1;
              waddr_o <= IdxW'(pos_q - CntW'(1));
              wdata_o <= '{base: prev_q.base, len: prev_q.len + size_q};
              free_q <= free_q + size_q;
              state_q <= S_DONE;
            end else if (used_q < CntW'(ListEntries)) begin
              new_q <= '{base: addr_q, len: size_q};
              pos_q <= used_q;
              state_q <= S_INS;
            end else begin
              res_fail_q <= 1'b1;
              lost_n_q <= lost_n_q + 32'd1;
              lost_b_q <= lost_b_q + size_q;
              state_q <= S_DONE;
            end
          end else begin
            state_q <= S_SCAN_W;
          end
        end
        S_SCAN_W: begin
          if (act_q == ACT_ALLOC) begin
            if (rdata_i.len >= size_q) begin
              res_addr_q <= rdata_i.base;
              free_q <= free_q - size_q;
              if (rdata_i.len == size_q) begin
                used_q <= used_q - CntW'(1);
                state_q <= S_RMV;
              end else begin
                we_o <= 1'b1;
                waddr_o <= IdxW'(pos_q);
                wdata_o <= '{base: rdata_i.base + size_q, len: rdata_i.len - size_q};
                state_q <= S_DONE;
              end
            end else begin
              pos_q <= pos_q + CntW'(1);
              state_q <= S_SCAN;
            end
          end else if (rdata_i.base > addr_q) begin
            if (pos_q != '0 && prev_q.base + prev_q.len == addr_q) begin
              we_o <= 1'b1;
              waddr_o <= IdxW'(pos_q - CntW'(1));
              free_q <= free_q + size_q;
              if (req_end == rdata_i.base) begin
                wdata_o <= '{base: prev_q.base, len: prev_q.len + size_q + rdata_i.len};
                used_q <= used_q - CntW'(1);
                state_q <= S_RMV;
              end else begin
                wdata_o <= '{base: prev_q.base, len: prev_q.len + size_q};
                state_q <= S_DONE;
              end
            end else if (req_end == rdata_i.base) begin
              we_o <= 1'b1;
              waddr_o <= IdxW'(pos_q);
              wdata_o <= '{base: addr_q, len: rdata_i.len + size_q};
              free_q <= free_q + size_q;
              state_q <= S_DONE;
            end else if (used_q < CntW'(ListEntries)) begin
              new_q <= '{base: addr_q, len: size_q};
              prev_q <= '{base: 32'(pos_q), len: '0};
              pos_q <= used_q;
              state_q <= S_INS;
            end else begin
              res_fail_q <= 1'b1;
              lost_n_q <= lost_n_q + 32'd1;
              lost_b_q <= lost_b_q + size_q;
              state_q <= S_DONE;
            end
          end else begin
            prev_q <= rdata_i;
            pos_q <= pos_q + CntW'(1);
            state_q <= S_SCAN;
          end
        end
        S_RMV: begin
          // move entry pos+1 down to pos, used_q already decremented
          if (pos_q >= used_q) begin
            state_q <= S_DONE;
          end else begin
            state_q <= S_RMV_W;
          end
        end
        S_RMV_W: begin
          we_o <= 1'b1;
          waddr_o <= IdxW'(pos_q);
          wdata_o <= rdata_i;
          pos_q <= pos_q + CntW'(1);
          state_q <= S_RMV;
        end
        S_INS: begin
          // move entry pos-1 up to pos until pos reaches insert point
          if (pos_q == CntW'(prev_q.base) || (!rd_q && pos_q == '0)) begin
            we_o <= 1'b1;
            waddr_o <= IdxW'(pos_q);
            wdata_o <= new_q;
            used_q <= used_q + CntW'(1);
            if (max_q < used_q + CntW'(1)) begin
              max_q <= used_q + CntW'(1);
            end
            free_q <= free_q + new_q.len;
            state_q <= S_DONE;
          end else begin
            state_q <= S_INS_W;
          end
        end
        S_INS_W: begin
          we_o <= 1'b1;
          waddr_o <= IdxW'(pos_q);
          wdata_o <= rdata_i;
          pos_q <= pos_q - CntW'(1);
          state_q <= S_INS;
        end
        S_DONE: begin
          alloc_addr_o <= res_addr_q;
          status_o <= res_fail_q;
          free_total_o <= free_q;
          entry_count_o <= 13'(used_q);
          peak_entries_o <= 13'(max_q);
          lost_count_o <= lost_n_q;
          lost_bytes_o <= lost_b_q;
          out_valid_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      // insert target marker: rd_q set once the scan ends, at the list tail or at an entry above a freed address
      if (state_q == S_SCAN && pos_q >= used_q) begin
        rd_q <= 1'b1;
        prev_q.base <= (pos_q >= used_q && act_q == ACT_FREE &&
                        !(pos_q != '0 && prev_q.base + prev_q.len == addr_q))
                       ? 32'(used_q) : prev_q.base;
      end else if (state_q == S_SCAN_W && act_q == ACT_FREE && rdata_i.base > addr_q) begin
        rd_q <= 1'b1;
      end
    end
  end
endmodule

FILE: rtl/first_fit_free_list_allocator_top.sv
`timescale 1ns / 1ps
// each word scans entries in order, then may shift entries to remove or insert one,
// then posts a result; one word at a time, next word taken once the result word is taken
// in the worst case scan and shift together cover the list once
// reset clears counters and totals at once; list memory is not cleared
module first_fit_free_list_allocator_top import ffa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] req_addr_i,
  input  logic [31:0] req_size_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] alloc_addr_o,
  output logic        status_o,
  output logic [31:0] free_total_o,
  output logic [12:0] entry_count_o,
  output logic [12:0] peak_entries_o,
  output logic [31:0] lost_count_o,
  output logic [31:0] lost_bytes_o
);
  logic          we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  ffa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .action_i, .req_addr_i, .req_size_i,
    .out_valid_o, .out_stall_i, .alloc_addr_o, .status_o, .free_total_o,
    .entry_count_o, .peak_entries_o, .lost_count_o, .lost_bytes_o,
    .we_o(we), .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr), .rdata_i(rdata)
  );

  ffa_ram #(.Width(EntW), .Depth(ListEntries)) u_list (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );
endmodule

FILE: rtl/ffa_checker.sv
`timescale 1ns / 1ps
// port-level checker for the allocator, bound to the top level
module ffa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] alloc_addr_o,
  input logic        status_o,
  input logic [12:0] entry_count_o,
  input logic [12:0] peak_entries_o
);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(alloc_addr_o))
    else $error("stalled word changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> entry_count_o <= peak_entries_o)
    else $error("count above peak");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> alloc_addr_o == 32'd0)
    else $error("failure with nonzero address");
endmodule

bind first_fit_free_list_allocator_top ffa_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .alloc_addr_o, .status_o, .entry_count_o, .peak_entries_o
);

FILE: tb/first_fit_free_list_allocator_top_tb.sv
`timescale 1ns / 1ps
// testbench for the first-fit free list allocator: directed table, then random words
module first_fit_free_list_allocator_top_tb import ffa_pkg::*;;

  typedef struct {
    logic [31:0] addr;
    logic        status;
    logic [31:0] total;
    logic [12:0] count;
    logic [12:0] peak;
    logic [31:0] lost_n;
    logic [31:0] lost_b;
  } result_t;

  typedef struct {
    action_e     act;
    logic [31:0] addr;
    logic [31:0] size;
    bit          typed;
    logic [31:0] exp_addr;
    logic        exp_status;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        action_i = 1'b0;
  logic [31:0] req_addr_i = '0;
  logic [31:0] req_size_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] alloc_addr_o;
  logic        status_o;
  logic [31:0] free_total_o;
  logic [12:0] entry_count_o;
  logic [12:0] peak_entries_o;
  logic [31:0] lost_count_o;
  logic [31:0] lost_bytes_o;

  first_fit_free_list_allocator_top DUT (.*);

  always #2 clk_i = ~clk_i;

  // model of the free list
  logic [31:0] fl_base [ListEntries];
  logic [31:0] fl_len  [ListEntries];
  int unsigned fl_used, fl_peak;
  logic [31:0] fl_lost_n, fl_lost_b, fl_free;

  result_t pending[$];
  int      errors = 0;
  int      send_idle = 0;
  int      recv_stall = 0;

  function automatic void fl_remove(int unsigned pos);
    if (fl_used == 0) return;
    fl_used--;
    for (int unsigned k = pos; k < fl_used; k++) begin
      fl_base[k] = fl_base[k + 1];
      fl_len[k]  = fl_len[k + 1];
    end
  endfunction

  function automatic result_t fl_apply(action_e act, logic [31:0] addr, logic [31:0] size);
    result_t     r;
    int unsigned pos;
    bit          done;
    r.addr = '0;
    r.status = 1'b0;
    done = 0;
    if (act == ACT_ALLOC) begin
      r.status = 1'b1;
      for (int unsigned k = 0; k < fl_used && !done; k++) begin
        if (fl_len[k] >= size) begin
          r.addr = fl_base[k];
          r.status = 1'b0;
          fl_base[k] += size;
          fl_len[k] -= size;
          if (fl_len[k] == 0) fl_remove(k);
          fl_free -= size;
          done = 1;
        end
      end
    end else begin
      pos = 0;
      while (pos < fl_used && fl_base[pos] <= addr) pos++;
      if (pos > 0 && fl_base[pos - 1] + fl_len[pos - 1] == addr) begin
        fl_len[pos - 1] += size;
        if (pos < fl_used && addr + size == fl_base[pos]) begin
          fl_len[pos - 1] += fl_len[pos];
          fl_remove(pos);
        end
        fl_free += size;
      end else if (pos < fl_used && addr + size == fl_base[pos]) begin
        fl_base[pos] = addr;
        fl_len[pos] += size;
        fl_free += size;
      end else if (fl_used < ListEntries) begin
        for (int unsigned k = fl_used; k > pos; k--) begin
          fl_base[k] = fl_base[k - 1];
          fl_len[k]  = fl_len[k - 1];
        end
        fl_used++;
        if (fl_peak < fl_used) fl_peak = fl_used;
        fl_base[pos] = addr;
        fl_len[pos] = size;
        fl_free += size;
      end else begin
        fl_lost_n++;
        fl_lost_b += size;
        r.status = 1'b1;
      end
    end
    r.total = fl_free;
    r.count = fl_used[12:0];
    r.peak = fl_peak[12:0];
    r.lost_n = fl_lost_n;
    r.lost_b = fl_lost_b;
    return r;
  endfunction

  task automatic send_word(action_e act, logic [31:0] addr, logic [31:0] size,
                           bit typed = 0, logic [31:0] ea = '0, logic es = 1'b0);
    result_t r;
    bit      taken;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    req_addr_i <= addr;
    req_size_i <= size;
    taken = 0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end
    r = fl_apply(act, addr, size);
    if (typed) begin
      r.addr = ea;
      r.status = es;
    end
    pending.push_back(r);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall);

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending.size() == 0) begin
        $error("unexpected word: alloc_addr %h", alloc_addr_o);
        errors++;
      end else begin
        e = pending.pop_front();
        if (alloc_addr_o !== e.addr) begin
          $error("alloc_addr exp %h got %h", e.addr, alloc_addr_o); errors++;
        end
        if (status_o !== e.status) begin
          $error("status exp %h got %h", e.status, status_o); errors++;
        end
        if (free_total_o !== e.total) begin
          $error("free_total exp %h got %h", e.total, free_total_o); errors++;
        end
        if (entry_count_o !== e.count) begin
          $error("entry_count exp %0d got %0d", e.count, entry_count_o); errors++;
        end
        if (peak_entries_o !== e.peak) begin
          $error("peak_entries exp %0d got %0d", e.peak, peak_entries_o); errors++;
        end
        if (lost_count_o !== e.lost_n) begin
          $error("lost_count exp %h got %h", e.lost_n, lost_count_o); errors++;
        end
        if (lost_bytes_o !== e.lost_b) begin
          $error("lost_bytes exp %h got %h", e.lost_b, lost_bytes_o); errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("first_fit_free_list_allocator_top_tb: FAIL");
    $finish;
  end

  row_t rows[$];
  int   pct_send[4] = '{0, 86, 0, 14};
  int   pct_recv[4] = '{0, 0, 86, 14};

  initial begin
    logic [31:0] a, s;
    int unsigned pick;
    fl_used = 0;
    fl_peak = 0;
    fl_lost_n = '0;
    fl_lost_b = '0;
    fl_free = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    rows = '{
      '{ACT_ALLOC, 32'h0, 32'h0, 1, 32'h0, 1'b1},           // empty list
      '{ACT_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, 1'b1},
      '{ACT_FREE, 32'h0, 32'h100, 1, 32'h0, 1'b0},
      '{ACT_ALLOC, 32'h0, 32'h10, 1, 32'h0, 1'b0},          // success at base zero
      '{ACT_ALLOC, 32'h0, 32'h0, 1, 32'h10, 1'b0},          // zero size
      '{ACT_FREE, 32'hFFFF_FF00, 32'h100, 0, 32'h0, 1'b0},  // end wraps to zero
      '{ACT_FREE, 32'h0, 32'h10, 0, 32'h0, 1'b0},
      '{ACT_FREE, 32'h200, 32'h0, 0, 32'h0, 1'b0},          // zero-length entry
      '{ACT_ALLOC, 32'h0, 32'h0, 0, 32'h0, 1'b0},
      '{ACT_FREE, 32'h300, 32'h50, 0, 32'h0, 1'b0},
      '{ACT_FREE, 32'h400, 32'h50, 0, 32'h0, 1'b0},
      '{ACT_FREE, 32'h350, 32'hB0, 0, 32'h0, 1'b0},         // merge both sides
      '{ACT_FREE, 32'h320, 32'h40, 0, 32'h0, 1'b0},         // overlap
      '{ACT_ALLOC, 32'h0, 32'hFFFF_FFFF, 1, 32'h0, 1'b1},
      '{ACT_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'h0, 1'b0},
      '{ACT_ALLOC, 32'hFFFF_FFFF, 32'h120, 0, 32'h0, 1'b0},
      '{ACT_ALLOC, 32'h0, 32'h1, 0, 32'h0, 1'b0}
    };
    foreach (rows[i])
      send_word(rows[i].act, rows[i].addr, rows[i].size, rows[i].typed,
                rows[i].exp_addr, rows[i].exp_status);

    for (int ph = 0; ph < 4; ph++) begin
      // hold off until the block has drained
      in_valid_i <= 1'b0;
      while (pending.size() != 0) @(negedge clk_i);
      send_idle = pct_send[ph];
      recv_stall = pct_recv[ph];
      for (int n = 0; n < 25; n++) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          a = $urandom_range(255) << 4;
          s = $urandom_range(1, 16) << 4;
          send_word(ACT_FREE, a, s);
        end else if (pick < 85) begin
          s = $urandom_range(0, 12) << 4;
          send_word(ACT_ALLOC, $urandom, s);
        end else begin
          send_word(action_e'($urandom_range(1)), $urandom, $urandom);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (errors == 0 && pending.size() == 0)
      $display("first_fit_free_list_allocator_top_tb: PASS");
    else
      $display("first_fit_free_list_allocator_top_tb: FAIL");
    $finish;
  end
endmodule
